// File: rtl/stereo_fir_filter_clip_unit_assert.svh
// assertion macros for the stereo fir filter unit checker
// no dependencies; included by the checker file
`ifndef STEREO_FIR_FILTER_CLIP_UNIT_ASSERT_SVH
`define STEREO_FIR_FILTER_CLIP_UNIT_ASSERT_SVH

// same-cycle implication
`define SFFC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sffc check failed");

// next-cycle implication
`define SFFC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sffc check failed");

`endif

// File: rtl/sffc_pkg.sv
// shared types and constants for the stereo fir filter unit
// no dependencies
package sffc_pkg;

   localparam int COEF_W         = 24;
   localparam int SAMPLE_W       = 16;
   localparam int OUT_W          = 16;
   localparam int INDEX_W        = 8;
   localparam int TAP_COUNT_W    = 9;
   localparam int PROD_W         = COEF_W + SAMPLE_W;
   localparam int OUT_LIMIT      = 32767;
   localparam int TAP_COUNT_INIT = 1;

   localparam int DEF_MAX_TAPS       = 256;
   localparam int DEF_COEF_FRAC_BITS = 20;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_FILTER = 1'b1
   } op_type;

   typedef struct packed {
      logic               push;
      logic               rotate;
      logic               load;
      logic [INDEX_W-1:0] load_index;
   } cell_ctrl_type;

   typedef struct packed {
      logic clear;
      logic gate;
      logic accumulate;
      logic finish;
   } mac_ctrl_type;

endpackage

// File: rtl/sffc_cell.sv
// one tap cell: holds a coefficient and a left/right history sample
// depends on sffc_pkg
module sffc_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sffc_pkg::cell_ctrl_type               ctrl,
   input  logic signed [sffc_pkg::COEF_W-1:0]    load_value,
   input  logic signed [sffc_pkg::SAMPLE_W-1:0]  prev_left,
   input  logic signed [sffc_pkg::SAMPLE_W-1:0]  prev_right,
   input  logic signed [sffc_pkg::SAMPLE_W-1:0]  next_left,
   input  logic signed [sffc_pkg::SAMPLE_W-1:0]  next_right,
   input  logic signed [sffc_pkg::COEF_W-1:0]    next_coef,
   output logic signed [sffc_pkg::SAMPLE_W-1:0]  left,
   output logic signed [sffc_pkg::SAMPLE_W-1:0]  right,
   output logic signed [sffc_pkg::COEF_W-1:0]    coef
);
   import sffc_pkg::*;

   logic signed [SAMPLE_W-1:0] left_ff, left_in;
   logic signed [SAMPLE_W-1:0] right_ff, right_in;
   logic signed [COEF_W-1:0]   coef_ff, coef_in;
   logic                       hit;

   assign hit = ctrl.load && (32'(ctrl.load_index) == 32'(CELL_INDEX));

   always_comb begin
      left_in  = left_ff;
      right_in = right_ff;
      coef_in  = coef_ff;
      if (ctrl.push) begin
         left_in  = prev_left;
         right_in = prev_right;
      end else if (ctrl.rotate) begin
         left_in  = next_left;
         right_in = next_right;
      end
      if (hit) begin
         coef_in = load_value;
      end else if (ctrl.rotate) begin
         coef_in = next_coef;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         right_ff <= '0;
         coef_ff  <= '0;
      end else begin
         left_ff  <= left_in;
         right_ff <= right_in;
         coef_ff  <= coef_in;
      end
   end

   assign left  = left_ff;
   assign right = right_ff;
   assign coef  = coef_ff;

endmodule

// File: rtl/sffc_mac.sv
// per-channel multiply-accumulate with truncating scale and clip
// depends on sffc_pkg
module sffc_mac #(
   parameter int MAX_TAPS       = sffc_pkg::DEF_MAX_TAPS,
   parameter int COEF_FRAC_BITS = sffc_pkg::DEF_COEF_FRAC_BITS
) (
   input  logic                                 clock,
   input  sffc_pkg::mac_ctrl_type               ctrl,
   input  logic signed [sffc_pkg::COEF_W-1:0]   coef,
   input  logic signed [sffc_pkg::SAMPLE_W-1:0] sample,
   output logic signed [sffc_pkg::OUT_W-1:0]    result
);
   import sffc_pkg::*;

   localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);

   logic signed [PROD_W-1:0] prod_full;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]         mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [ACC_W-1:0]         quot;
   logic [OUT_W-1:0]         clipped;

   assign prod_full = PROD_W'(coef) * PROD_W'(sample);

   always_comb begin
      prod_in = ctrl.gate ? prod_full : '0;
      acc_in  = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.accumulate) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
      neg_in = neg_ff;
      mag_in = mag_ff;
      if (ctrl.finish) begin
         neg_in = acc_ff[ACC_W-1];
         mag_in = acc_ff[ACC_W-1] ? (~acc_ff + 1'b1) : acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
   end

   assign quot    = mag_ff >> COEF_FRAC_BITS;
   assign clipped = (quot > ACC_W'(OUT_LIMIT)) ? OUT_W'(OUT_LIMIT) : quot[OUT_W-1:0];
   assign result  = neg_ff ? (OUT_W'(0) - clipped) : clipped;

endmodule

// File: rtl/stereo_fir_filter_clip_unit.sv
// top level of the stereo fir filter unit: tap cell ring, two macs, control
// depends on sffc_pkg, sffc_cell, sffc_mac
//
// A sample beat keeps the block busy from acceptance until its result is
// loaded: the coefficients and histories sit in a ring of MAX_TAPS cells
// that turns once per cycle past a single multiply-accumulate per channel, and
// the ring makes one full turn per sample so it ends where it started; then the
// product register drains, sign and magnitude are formed and the result
// register is loaded, which waits while a held result is not yet taken. A
// coefficient load beat gives no result and leaves the block ready. A finished
// result waits in the output register while the next beat is accepted and
// worked on. Reset clears all cells at once; no clearing pass.
module stereo_fir_filter_clip_unit #(
   parameter int MAX_TAPS       = sffc_pkg::DEF_MAX_TAPS,
   parameter int COEF_FRAC_BITS = sffc_pkg::DEF_COEF_FRAC_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_operation,
   input  logic        [sffc_pkg::INDEX_W-1:0]     req_coef_index,
   input  logic signed [sffc_pkg::COEF_W-1:0]      req_coef_value,
   input  logic signed [sffc_pkg::SAMPLE_W-1:0]    req_left_sample,
   input  logic signed [sffc_pkg::SAMPLE_W-1:0]    req_right_sample,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [sffc_pkg::OUT_W-1:0]       rsp_left_out,
   output logic signed [sffc_pkg::OUT_W-1:0]       rsp_right_out,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic        [sffc_pkg::TAP_COUNT_W-1:0] csr_tap_count
);
   import sffc_pkg::*;

   localparam int STEP_W = $clog2(MAX_TAPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH,
      ST_OUTPUT
   } state_type;

   state_type                state_ff, state_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     accum_ff, accum_in;
   logic [TAP_COUNT_W-1:0]   tap_count_ff, tap_count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]  left_out_ff, left_out_in;
   logic signed [OUT_W-1:0]  right_out_ff, right_out_in;

   logic                     req_fire;
   logic                     sample_fire;
   logic                     slot_free;
   cell_ctrl_type            cell_ctrl;
   mac_ctrl_type             mac_ctrl;
   logic signed [OUT_W-1:0]  left_result;
   logic signed [OUT_W-1:0]  right_result;

   logic signed [SAMPLE_W-1:0] left_q  [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] right_q [MAX_TAPS];
   logic signed [COEF_W-1:0]   coef_q  [MAX_TAPS];

   assign req_ready   = (state_ff == ST_IDLE);
   assign csr_ready   = 1'b1;
   assign req_fire    = req_valid && req_ready;
   assign sample_fire = req_fire && (req_operation == OP_FILTER);
   assign slot_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cell_ctrl.push       = sample_fire;
      cell_ctrl.rotate     = (state_ff == ST_RUN);
      cell_ctrl.load       = req_fire && (req_operation == OP_LOAD);
      cell_ctrl.load_index = req_coef_index;

      mac_ctrl.clear      = sample_fire;
      mac_ctrl.gate       = (state_ff == ST_RUN) && (32'(step_ff) < 32'(tap_count_ff));
      mac_ctrl.accumulate = accum_ff;
      mac_ctrl.finish     = (state_ff == ST_FINISH);
   end

   // tap ring
   for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
      localparam int NEXT = (i + 1) % MAX_TAPS;
      logic signed [SAMPLE_W-1:0] prev_left;
      logic signed [SAMPLE_W-1:0] prev_right;

      if (i == 0) begin : g_head
         assign prev_left  = req_left_sample;
         assign prev_right = req_right_sample;
      end else begin : g_body
         assign prev_left  = left_q[i-1];
         assign prev_right = right_q[i-1];
      end

      sffc_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .load_value (req_coef_value),
         .prev_left  (prev_left),
         .prev_right (prev_right),
         .next_left  (left_q[NEXT]),
         .next_right (right_q[NEXT]),
         .next_coef  (coef_q[NEXT]),
         .left       (left_q[i]),
         .right      (right_q[i]),
         .coef       (coef_q[i])
      );
   end

   sffc_mac #(
      .MAX_TAPS       (MAX_TAPS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_mac_left (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .coef   (coef_q[0]),
      .sample (left_q[0]),
      .result (left_result)
   );

   sffc_mac #(
      .MAX_TAPS       (MAX_TAPS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_mac_right (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .coef   (coef_q[0]),
      .sample (right_q[0]),
      .result (right_result)
   );

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      accum_in     = (state_ff == ST_RUN);
      tap_count_in = csr_valid ? csr_tap_count : tap_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      left_out_in  = left_out_ff;
      right_out_in = right_out_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (sample_fire) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(MAX_TAPS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               left_out_in  = left_result;
               right_out_in = right_result;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         accum_ff     <= 1'b0;
         tap_count_ff <= TAP_COUNT_W'(TAP_COUNT_INIT);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         accum_ff     <= accum_in;
         tap_count_ff <= tap_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      left_out_ff  <= left_out_in;
      right_out_ff <= right_out_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = left_out_ff;
   assign rsp_right_out = right_out_ff;

endmodule

// File: rtl/sffc_checker.sv
// port-level checks for the stereo fir filter unit, bound to the top level
// depends on stereo_fir_filter_clip_unit_assert.svh
`include "stereo_fir_filter_clip_unit_assert.svh"

module sffc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_operation,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_left_out,
   input logic [15:0] rsp_right_out
);

   // held result beat keeps its data
   `SFFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_left_out) && $stable(rsp_right_out))

   // clip never lets the most negative code through
   `SFFC_ASSERT_NOW(a_left_clip, clock, reset, rsp_valid, rsp_left_out != 16'h8000)
   `SFFC_ASSERT_NOW(a_right_clip, clock, reset, rsp_valid, rsp_right_out != 16'h8000)

   // a sample beat keeps the block busy on the following cycle
   `SFFC_ASSERT_NEXT(a_sample_busy, clock, reset, req_valid && req_ready && req_operation, !req_ready)

endmodule

bind stereo_fir_filter_clip_unit sffc_checker u_sffc_checker (.*);

// File: verif/stereo_fir_filter_clip_unit_checker.sv
// checker for the stereo fir filter unit: watches the request, result and csr channels,
// predicts each filtered stereo pair and compares it with the result beats
// depends on sffc_pkg
module stereo_fir_filter_clip_unit_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_ready,
   input  logic                                    req_operation,
   input  logic        [sffc_pkg::INDEX_W-1:0]     req_coef_index,
   input  logic signed [sffc_pkg::COEF_W-1:0]      req_coef_value,
   input  logic signed [sffc_pkg::SAMPLE_W-1:0]    req_left_sample,
   input  logic signed [sffc_pkg::SAMPLE_W-1:0]    req_right_sample,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   input  logic signed [sffc_pkg::OUT_W-1:0]       rsp_left_out,
   input  logic signed [sffc_pkg::OUT_W-1:0]       rsp_right_out,
   input  logic                                    csr_valid,
   input  logic                                    csr_ready,
   input  logic        [sffc_pkg::TAP_COUNT_W-1:0] csr_tap_count,
   output int                                      fail_count,
   output int                                      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import sffc_pkg::*;

   localparam int MAX_TAPS  = DEF_MAX_TAPS;
   localparam int FRAC_BITS = DEF_COEF_FRAC_BITS;

   typedef struct packed {
      logic signed [OUT_W-1:0] left;
      logic signed [OUT_W-1:0] right;
   } stereo_pair_type;

   logic signed [COEF_W-1:0]   coef_mem  [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] left_mem  [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] right_mem [MAX_TAPS];
   int                         newest;
   logic [TAP_COUNT_W-1:0]     taps_in_use;
   stereo_pair_type            expected_pairs [$];
   int                         mismatches = 0;

   assign fail_count = mismatches;

   // drop the fraction bits toward zero, then saturate symmetrically
   function automatic logic signed [OUT_W-1:0] truncate_clip(input longint acc);
      longint mag;
      mag = (acc < 0) ? -acc : acc;
      mag = mag >> FRAC_BITS;
      if (mag > OUT_LIMIT)
         mag = OUT_LIMIT;
      return OUT_W'((acc < 0) ? -mag : mag);
   endfunction

   task automatic report(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin : track
      longint          left_acc;
      longint          right_acc;
      int              taps;
      int              pos;
      stereo_pair_type want;
      if (reset) begin
         for (int i = 0; i < MAX_TAPS; i++) begin
            coef_mem[i]  = '0;
            left_mem[i]  = '0;
            right_mem[i] = '0;
         end
         newest      = 0;
         taps_in_use = TAP_COUNT_W'(TAP_COUNT_INIT);
         expected_pairs.delete();
         pending <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pairs.size() == 0) begin
               report($sformatf("result beat %0d/%0d with nothing expected",
                                rsp_left_out, rsp_right_out));
            end else begin
               want = expected_pairs.pop_front();
               if (rsp_left_out !== want.left)
                  report($sformatf("left_out %0d, expected %0d", rsp_left_out, want.left));
               if (rsp_right_out !== want.right)
                  report($sformatf("right_out %0d, expected %0d", rsp_right_out, want.right));
            end
         end
         if (csr_valid && csr_ready)
            taps_in_use = csr_tap_count;
         if (req_valid && req_ready) begin
            if (req_operation == OP_LOAD) begin
               coef_mem[req_coef_index] = req_coef_value;
            end else begin
               newest = (newest == MAX_TAPS - 1) ? 0 : newest + 1;
               left_mem[newest]  = req_left_sample;
               right_mem[newest] = req_right_sample;
               taps = (taps_in_use > MAX_TAPS) ? MAX_TAPS : int'(taps_in_use);
               pos = newest;
               left_acc  = 0;
               right_acc = 0;
               for (int k = 0; k < taps; k++) begin
                  left_acc  += longint'(coef_mem[k]) * longint'(left_mem[pos]);
                  right_acc += longint'(coef_mem[k]) * longint'(right_mem[pos]);
                  pos = (pos == 0) ? MAX_TAPS - 1 : pos - 1;
               end
               want.left  = truncate_clip(left_acc);
               want.right = truncate_clip(right_acc);
               expected_pairs.push_back(want);
            end
         end
         pending <= expected_pairs.size();
      end
   end

endmodule

// File: verif/stereo_fir_filter_clip_unit_tb.sv
// testbench top for the stereo fir filter unit: clock, reset, stimulus and verdict
// depends on sffc_pkg, stereo_fir_filter_clip_unit and stereo_fir_filter_clip_unit_checker
module stereo_fir_filter_clip_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sffc_pkg::*;

   localparam int DRAIN_CYCLES    = DEF_MAX_TAPS + 8;
   localparam int LONG_HOLD       = 1500;
   localparam int ITEMS_PER_PHASE = 148;
   localparam int PHASES          = 10;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic                          req_operation;
   logic        [INDEX_W-1:0]     req_coef_index;
   logic signed [COEF_W-1:0]      req_coef_value;
   logic signed [SAMPLE_W-1:0]    req_left_sample;
   logic signed [SAMPLE_W-1:0]    req_right_sample;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic signed [OUT_W-1:0]       rsp_left_out;
   logic signed [OUT_W-1:0]       rsp_right_out;
   logic                          csr_valid;
   logic                          csr_ready;
   logic        [TAP_COUNT_W-1:0] csr_tap_count;
   int                            fail_count;
   int                            pending;
   bit                            calm = 0;
   bit                            long_hold_due = 0;
   bit                            long_hold_done = 0;

   stereo_fir_filter_clip_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_coef_index   (req_coef_index),
      .req_coef_value   (req_coef_value),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_left_out     (rsp_left_out),
      .rsp_right_out    (rsp_right_out),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_tap_count    (csr_tap_count)
   );

   stereo_fir_filter_clip_unit_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_coef_index   (req_coef_index),
      .req_coef_value   (req_coef_value),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_left_out     (rsp_left_out),
      .rsp_right_out    (rsp_right_out),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_tap_count    (csr_tap_count),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("stereo_fir_filter_clip_unit_tb NOT OK");
      $finish;
   end

   // random value of the given width, sign extended
   function automatic int rand_signed(input int bits);
      int v;
      v = $urandom;
      return (v <<< (32 - bits)) >>> (32 - bits);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: return 16'sh7fff;
               1: return 16'sh8000;
               2: return 16'sh0000;
               default: return 16'shffff;
            endcase
         end
         1, 2: return SAMPLE_W'(rand_signed($urandom_range(1, 8)));
         default: return SAMPLE_W'(rand_signed(SAMPLE_W));
      endcase
   endfunction

   task automatic send_beat(input op_type op, input logic [INDEX_W-1:0] idx,
                            input logic signed [COEF_W-1:0] coef,
                            input logic signed [SAMPLE_W-1:0] left,
                            input logic signed [SAMPLE_W-1:0] right);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_coef_index   <= idx;
      req_coef_value   <= coef;
      req_left_sample  <= left;
      req_right_sample <= right;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic load_coef(input logic [INDEX_W-1:0] idx, input logic signed [COEF_W-1:0] coef);
      send_beat(OP_LOAD, idx, coef, rand_sample(), rand_sample());
   endtask

   task automatic filter_pair(input logic signed [SAMPLE_W-1:0] left,
                              input logic signed [SAMPLE_W-1:0] right);
      send_beat(OP_FILTER, INDEX_W'($urandom), COEF_W'($urandom), left, right);
   endtask

   // stop sending, wait for every result, then let the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_tap_count(input logic [TAP_COUNT_W-1:0] taps);
      csr_valid     <= 1'b1;
      csr_tap_count <= taps;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic random_item(input int taps);
      int lim;
      int idx;
      int bits;
      lim  = (taps < 1) ? 1 : (taps > DEF_MAX_TAPS) ? DEF_MAX_TAPS : taps;
      idx  = ($urandom_range(0, 3) != 0) ? $urandom_range(0, lim - 1) : $urandom_range(0, 255);
      bits = ($urandom_range(0, 3) == 0) ? COEF_W : $urandom_range(1, 20);
      if ($urandom_range(0, 99) < 35)
         load_coef(INDEX_W'(idx), COEF_W'(rand_signed(bits)));
      else
         filter_pair(rand_sample(), rand_sample());
   endtask

   initial begin
      rsp_ready <= 1'b0;
      forever begin
         if (long_hold_due && !long_hold_done) begin
            long_hold_done = 1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int plan [PHASES];
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_operation    <= OP_LOAD;
      req_coef_index   <= '0;
      req_coef_value   <= '0;
      req_left_sample  <= '0;
      req_right_sample <= '0;
      csr_valid        <= 1'b0;
      csr_tap_count    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // single tap from reset, empty coefficients
      filter_pair(16'sd100, -16'sd100);
      load_coef(8'd0, 24'sh7fffff);
      filter_pair(16'sh7fff, 16'sh8000);
      load_coef(8'd0, 24'sh800000);
      filter_pair(16'sh8000, 16'sh7fff);
      load_coef(8'd0, 24'sd1048576);
      filter_pair(16'sh8000, 16'sh7fff);
      filter_pair(-16'sd5, 16'sd12);
      load_coef(8'd0, 24'sd1);
      filter_pair(-16'sd1, 16'sh7fff);
      load_coef(8'd0, 24'sd524288);
      filter_pair(-16'sd3, 16'sd3);
      load_coef(8'd255, -24'sd1);
      load_coef(8'd1, 24'sd1048576);
      settle();
      write_tap_count(9'd2);
      filter_pair(16'sd1000, -16'sd1000);
      settle();
      write_tap_count(9'd0);
      filter_pair(16'sh7fff, 16'sh8000);
      filter_pair(-16'sd1234, 16'sd4321);
      settle();
      write_tap_count(9'd511);
      filter_pair(16'sh7fff, 16'sh8000);
      filter_pair(16'sh8000, 16'sh7fff);
      settle();
      write_tap_count(9'd256);
      filter_pair(-16'sd77, 16'sd77);

      plan = '{256, 3, 1, 255, 0, 17, 0, 511, 0, 256};
      plan[6] = $urandom_range(4, 254);
      plan[8] = $urandom_range(257, 510);
      for (int p = 0; p < PHASES; p++) begin
         settle();
         write_tap_count(TAP_COUNT_W'(plan[p]));
         if (p == 1)
            long_hold_due = 1;
         if (p == PHASES - 1)
            calm = 1;
         repeat (ITEMS_PER_PHASE) random_item(plan[p]);
      end
      settle();

      if (fail_count == 0 && pending == 0)
         $display("stereo_fir_filter_clip_unit_tb OK");
      else
         $display("stereo_fir_filter_clip_unit_tb NOT OK");
      $finish;
   end

endmodule
